FILE: src/fpd_pkg.sv
// Shared types and constants for the frame pixel difference block.
package fpd_pkg;

    localparam int COUNT_BITS   = 24;
    localparam int PIX_W        = 8;
    localparam int OUT_COUNT_W  = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int SUM_W        = PIX_W + 2;

    localparam logic [PIX_W-1:0]      PIX_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_DIFF_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_SELECT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE_PLANE = 2'd3;

    localparam logic [1:0] SEL_ALL = 2'd0;
    localparam logic [1:0] SEL_C0  = 2'd1;
    localparam logic [1:0] SEL_C1  = 2'd2;
    localparam logic [1:0] SEL_C2  = 2'd3;

    typedef struct packed {
        logic             diff_mode;
        logic [1:0]       comp_select;
        logic [PIX_W-1:0] threshold;
        logic             single_plane;
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] first_c0;
        logic [PIX_W-1:0] first_c1;
        logic [PIX_W-1:0] first_c2;
        logic [PIX_W-1:0] second_c0;
        logic [PIX_W-1:0] second_c1;
        logic [PIX_W-1:0] second_c2;
        logic             frame_end;
    } t_pixel_pair;

endpackage

FILE: src/fpd_cfg_regs.sv
// Configuration register file for the frame pixel difference block.
module fpd_cfg_regs
    import fpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DIFF_MODE:    r_cfg.diff_mode    <= i_cfg_data[0];
                REG_COMP_SELECT:  r_cfg.comp_select  <= i_cfg_data[1:0];
                REG_THRESHOLD:    r_cfg.threshold    <= i_cfg_data[PIX_W-1:0];
                REG_SINGLE_PLANE: r_cfg.single_plane <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/fpd_diff.sv
// Per-pixel difference logic: absolute differences, sum or threshold test.
module fpd_diff
    import fpd_pkg::*;
(
    input  t_cfg             i_cfg,
    input  t_pixel_pair      i_pix,
    output logic [PIX_W-1:0] o_result
);

    logic [PIX_W-1:0] d0, d1, d2;
    logic [2:0]       use_c;
    logic [SUM_W-1:0] sum;
    logic             any_over;

    function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        d0 = abs_diff(i_pix.first_c0, i_pix.second_c0);
        d1 = abs_diff(i_pix.first_c1, i_pix.second_c1);
        d2 = abs_diff(i_pix.first_c2, i_pix.second_c2);

        if (i_cfg.single_plane) begin
            use_c = 3'b001;
        end else begin
            case (i_cfg.comp_select)
                SEL_ALL: use_c = 3'b111;
                SEL_C0:  use_c = 3'b001;
                SEL_C1:  use_c = 3'b010;
                SEL_C2:  use_c = 3'b100;
                default: use_c = 3'b111;
            endcase
        end

        sum = (use_c[0] ? SUM_W'(d0) : '0)
            + (use_c[1] ? SUM_W'(d1) : '0)
            + (use_c[2] ? SUM_W'(d2) : '0);

        any_over = (use_c[0] && d0 > i_cfg.threshold)
                || (use_c[1] && d1 > i_cfg.threshold)
                || (use_c[2] && d2 > i_cfg.threshold);

        if (i_cfg.diff_mode) begin
            o_result = any_over ? PIX_MAX : '0;
        end else begin
            o_result = (sum > SUM_W'(PIX_MAX)) ? PIX_MAX : sum[PIX_W-1:0];
        end
    end

endmodule

FILE: src/frame_pixel_difference.sv
// Top level of the frame pixel difference block: pipeline, counter, checks.
//
// One pixel pair enters per clock and its difference pixel leaves through an
// input register and a result register; a new request is taken every cycle
// unless i_stall holds a result in the output register while the input
// register is also full. The difference and threshold logic sits between
// the two registers, and the running count of nonzero results is updated
// when a result is loaded, cleared after the frame-end pixel. Configuration
// takes effect on the next request only if the user writes it while the block is idle; the block does not check this.
module frame_pixel_difference
    import fpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [PIX_W-1:0]       i_first_c0,
    input  logic [PIX_W-1:0]       i_first_c1,
    input  logic [PIX_W-1:0]       i_first_c2,
    input  logic [PIX_W-1:0]       i_second_c0,
    input  logic [PIX_W-1:0]       i_second_c1,
    input  logic [PIX_W-1:0]       i_second_c2,
    input  logic                   i_frame_end,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [PIX_W-1:0]       o_pixel_result,
    output logic [OUT_COUNT_W-1:0] o_differing_count,
    output logic                   o_frame_done
);

    t_cfg              cfg;
    t_pixel_pair       r_pix;
    logic              r_v1;
    logic              r_v2;
    logic [PIX_W-1:0]  r_result;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic              r_frame_done;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [PIX_W-1:0]  w_result;
    logic [31:0]       w_count_ext;
    logic              en1, en2;

    fpd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fpd_diff u_diff (
        .i_cfg    (cfg),
        .i_pix    (r_pix),
        .o_result (w_result)
    );

    assign en2     = !r_v2 || !i_stall;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_comb begin
        n_count = r_count;
        if (w_result != '0 && r_count != COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end
        w_count_ext = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_count <= '0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
                if (r_v1) begin
                    // count clears after the frame-end pixel's result is taken
                    r_count <= r_pix.frame_end ? '0 : n_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_valid) begin
            r_pix <= '{first_c0:  i_first_c0,  first_c1:  i_first_c1,
                       first_c2:  i_first_c2,  second_c0: i_second_c0,
                       second_c1: i_second_c1, second_c2: i_second_c2,
                       frame_end: i_frame_end};
        end
        if (en2 && r_v1) begin
            r_result     <= w_result;
            r_out_count  <= w_count_ext[OUT_COUNT_W-1:0];
            r_frame_done <= r_pix.frame_end;
        end
    end

    assign o_valid           = r_v2;
    assign o_pixel_result    = r_result;
    assign o_differing_count = r_out_count;
    assign o_frame_done      = r_frame_done;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2))
        else $error("input stalled while pipeline has room");

    a_count_cleared_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && o_frame_done) |-> (r_count == '0))
        else $error("running count not cleared after frame end");

    a_count_increments: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && r_v1 && w_result != '0 && !r_pix.frame_end && r_count != COUNT_MAX)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("running count missed a nonzero result");

    a_count_matches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && r_v1) |=> (o_differing_count == $past(w_count_ext[OUT_COUNT_W-1:0])))
        else $error("output count does not match loaded count");

endmodule
